// ----- sv/knn_pkg.sv -----
`default_nettype none

package knn_pkg;

  // Field widths of the ports
  localparam int unsigned OpW    = 2;
  localparam int unsigned PointW = 10;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned NbW    = 10;
  localparam int unsigned DistW  = 32;
  localparam int unsigned KCntW  = 5;

  // Defaults for the top-level parameters
  localparam int unsigned MaxKDefault      = 16;
  localparam int unsigned NumPointsDefault = 1024;

  // Slots in use after reset
  localparam logic [KCntW-1:0] KCountReset = 5'd16;

  typedef enum logic [OpW-1:0] {
    OpUpdate    = 2'd0,
    OpRead      = 2'd1,
    OpReadClear = 2'd2,
    OpSeed      = 2'd3
  } knn_op_e;

  // Write enables of the list store
  typedef struct packed {
    logic id;
    logic distance;
    logic mark;
    logic cnt;
  } knn_we_t;

endpackage

`default_nettype wire

// ----- sv/knn_store.sv -----
`default_nettype none

module knn_store #(
  parameter int unsigned MAX_K      = knn_pkg::MaxKDefault,
  parameter int unsigned NUM_POINTS = knn_pkg::NumPointsDefault
) (
  input  wire  logic                                clk_i,
  input  wire  knn_pkg::knn_we_t                    we_i,
  input  wire  logic [$clog2(NUM_POINTS)-1:0]       pt_i,
  input  wire  logic [((MAX_K > 1) ? $clog2(MAX_K) : 1)-1:0] slot_i,
  input  wire  logic [knn_pkg::NbW-1:0]             id_i,
  input  wire  logic [knn_pkg::DistW-1:0]           dist_i,
  input  wire  logic [MAX_K-1:0]                    marks_i,
  input  wire  logic [$clog2(MAX_K+1)-1:0]          cnt_i,
  output logic       [knn_pkg::NbW-1:0]             id_o,
  output logic       [knn_pkg::DistW-1:0]           dist_o,
  output logic       [MAX_K-1:0]                    marks_o,
  output logic       [$clog2(MAX_K+1)-1:0]          cnt_o
);

  localparam int unsigned PW       = $clog2(NUM_POINTS);
  localparam int unsigned SW       = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned CW       = $clog2(MAX_K + 1);
  localparam int unsigned EntDepth = NUM_POINTS << SW;

  // Per-slot entries, addressed by point and slot
  logic [knn_pkg::NbW-1:0]   id_mem   [EntDepth];
  logic [knn_pkg::DistW-1:0] dist_mem [EntDepth];
  // Per-point rows: new marks of all slots, and fill count
  logic [MAX_K-1:0]          mark_mem [NUM_POINTS];
  logic [CW-1:0]             cnt_mem  [NUM_POINTS];

  logic [PW+SW-1:0] ent_addr;

  assign ent_addr = {pt_i, slot_i};

  // Slot entries: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we_i.id) begin
      id_mem[ent_addr] <= id_i;
    end
    if (we_i.distance) begin
      dist_mem[ent_addr] <= dist_i;
    end
    id_o   <= id_mem[ent_addr];
    dist_o <= dist_mem[ent_addr];
  end

  // Point rows: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we_i.mark) begin
      mark_mem[pt_i] <= marks_i;
    end
    if (we_i.cnt) begin
      cnt_mem[pt_i] <= cnt_i;
    end
    marks_o <= mark_mem[pt_i];
    cnt_o   <= cnt_mem[pt_i];
  end

endmodule

`default_nettype wire

// ----- sv/knn_neighbor_list_update.sv -----
`default_nettype none

// Channel  | Direction | Handshake                 | Beat contents
// ---------+-----------+---------------------------+----------------------------------------
// config   | in        | cfg_we_i                  | cfg_wdata_i (k_count)
// request  | in        | in_valid_i / in_ready_o   | opcode, point, slot, neighbor, distance
// result   | out       | out_valid_o / out_ready_i | updated, entry_neighbor/_distance/_is_new/_empty
//
// Read, clear, seed and filling updates go from IDLE through FETCH, DECIDE and OUT back to IDLE.
// An update on a full list adds SCAN over the K effective slots, TAIL and EVAL: the scan
// reads one slot per cycle from the list store through one shared compare unit.
// After reset a clearing pass over all NUM_POINTS rows zeroes fill counts and sets new
// marks; in_ready_o stays low meanwhile, configuration writes are taken.
// The result sits in an output register; a new request is taken while it waits, and a
// result that finds the register still full holds the sequencer in its last step.

module knn_neighbor_list_update #(
  parameter int unsigned MAX_K      = knn_pkg::MaxKDefault,
  parameter int unsigned NUM_POINTS = knn_pkg::NumPointsDefault
) (
  input  wire  logic                          clk_i,
  input  wire  logic                          rst_ni,
  input  wire  logic                          cfg_we_i,
  input  wire  logic [knn_pkg::KCntW-1:0]     cfg_wdata_i,
  input  wire  logic                          in_valid_i,
  output logic                                in_ready_o,
  input  wire  logic [knn_pkg::OpW-1:0]       opcode_i,
  input  wire  logic [knn_pkg::PointW-1:0]    point_i,
  input  wire  logic [knn_pkg::SlotW-1:0]     slot_i,
  input  wire  logic [knn_pkg::NbW-1:0]       neighbor_i,
  input  wire  logic [knn_pkg::DistW-1:0]     distance_i,
  output logic                                out_valid_o,
  input  wire  logic                          out_ready_i,
  output logic                                updated_o,
  output logic       [knn_pkg::NbW-1:0]       entry_neighbor_o,
  output logic       [knn_pkg::DistW-1:0]     entry_distance_o,
  output logic                                entry_is_new_o,
  output logic                                entry_empty_o
);

  localparam int unsigned PW = $clog2(NUM_POINTS);
  localparam int unsigned SW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned CW = $clog2(MAX_K + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_DECIDE,
    S_SCAN,
    S_TAIL,
    S_EVAL,
    S_OUT
  } state_e;

  state_e                   state_q;
  logic [knn_pkg::KCntW-1:0] k_count_q;

  // Request registers
  knn_pkg::knn_op_e         op_q;
  logic [PW-1:0]            pt_q;
  logic                     pt_ok_q;
  logic [SW-1:0]            slot_q;
  logic                     slot_ok_q;
  logic [knn_pkg::NbW-1:0]  nb_q;
  logic [knn_pkg::DistW-1:0] dist_q;

  // Scan registers
  logic [SW-1:0]            idx_q;
  logic                     pend_q;
  logic [SW-1:0]            pend_idx_q;
  logic                     dup_q;
  logic                     found_q;
  logic [knn_pkg::DistW-1:0] best_q;
  logic [SW-1:0]            best_idx_q;

  logic [PW-1:0]            clr_q;

  // Staged result
  logic                     res_upd_q;
  logic [knn_pkg::NbW-1:0]  res_nb_q;
  logic [knn_pkg::DistW-1:0] res_dist_q;
  logic                     res_new_q;
  logic                     res_empty_q;

  // Output register
  logic                     out_valid_q;
  logic                     out_upd_q;
  logic [knn_pkg::NbW-1:0]  out_nb_q;
  logic [knn_pkg::DistW-1:0] out_dist_q;
  logic                     out_new_q;
  logic                     out_empty_q;
  logic                     out_load;

  // Store ports
  knn_pkg::knn_we_t         we;
  logic [PW-1:0]            st_pt;
  logic [SW-1:0]            st_slot;
  logic [MAX_K-1:0]         st_wr_marks;
  logic [CW-1:0]            st_wr_cnt;
  logic [knn_pkg::NbW-1:0]  st_id;
  logic [knn_pkg::DistW-1:0] st_dist;
  logic [MAX_K-1:0]         st_marks;
  logic [CW-1:0]            st_cnt;

  // Decode helpers
  logic [31:0]              pt_ext;
  logic [31:0]              slot_ext;
  logic [31:0]              k_ext;
  logic [31:0]              effk32;
  logic [31:0]              last32;
  logic [31:0]              cnt32;
  logic [CW-1:0]            effk;
  logic [SW-1:0]            last_idx;
  logic [SW-1:0]            fill_idx;
  logic                     list_full;
  logic                     slot_empty;
  logic                     op_valid;
  logic                     clearing;
  logic                     do_fill;
  logic                     do_seed;
  logic                     do_clr;
  logic                     do_rep;
  logic                     scan_dup;
  logic                     scan_gt;
  logic [MAX_K-1:0]         slot_mask;

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign updated_o        = out_upd_q;
  assign entry_neighbor_o = out_nb_q;
  assign entry_distance_o = out_dist_q;
  assign entry_is_new_o   = out_new_q;
  assign entry_empty_o    = out_empty_q;

  // Advance the staged result when the output register is free
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Effective slot count, saturated to 1..MAX_K
  assign k_ext    = 32'(k_count_q);
  assign effk32   = (k_ext == 32'd0) ? 32'd1 : ((k_ext > MAX_K) ? 32'(MAX_K) : k_ext);
  assign effk     = effk32[CW-1:0];
  assign last32   = effk32 - 32'd1;
  assign last_idx = last32[SW-1:0];

  assign pt_ext   = 32'(point_i);
  assign slot_ext = 32'(slot_i);

  // List status from the point row read in FETCH
  assign cnt32      = 32'(st_cnt);
  assign fill_idx   = cnt32[SW-1:0];
  assign list_full  = !(st_cnt < effk);
  assign slot_empty = 32'(slot_q) >= cnt32;
  assign op_valid   = pt_ok_q && ((op_q == knn_pkg::OpUpdate) || slot_ok_q);

  // Decide which store writes happen this cycle
  assign clearing = (state_q == S_CLEAR);
  assign do_fill  = (state_q == S_DECIDE) && pt_ok_q && (op_q == knn_pkg::OpUpdate)
                    && !list_full;
  assign do_seed  = (state_q == S_DECIDE) && op_valid && (op_q == knn_pkg::OpSeed);
  assign do_clr   = (state_q == S_DECIDE) && op_valid && (op_q == knn_pkg::OpReadClear);
  assign do_rep   = (state_q == S_EVAL) && !dup_q && found_q && (dist_q < best_q);

  assign we.id       = do_fill || do_seed || do_rep;
  assign we.distance = do_fill || do_rep;
  assign we.mark     = do_fill || do_clr || do_rep || clearing;
  assign we.cnt      = do_fill || clearing;

  // Pick the store address
  assign st_pt = clearing ? clr_q : pt_q;

  always_comb begin
    unique case (state_q)
      S_DECIDE: st_slot = do_fill ? fill_idx : slot_q;
      S_SCAN:   st_slot = idx_q;
      S_EVAL:   st_slot = best_idx_q;
      default:  st_slot = slot_q;
    endcase
  end

  always_comb begin
    slot_mask          = '0;
    slot_mask[st_slot] = 1'b1;
  end

  // Set the mark on a write, drop it on a clear, all ones on the reset pass
  always_comb begin
    if (clearing) begin
      st_wr_marks = '1;
    end else if (do_clr) begin
      st_wr_marks = st_marks & ~slot_mask;
    end else begin
      st_wr_marks = st_marks | slot_mask;
    end
  end

  assign st_wr_cnt = clearing ? '0 : (st_cnt + CW'(1));

  // Shared compare unit of the scan
  assign scan_dup = (st_id == nb_q);
  assign scan_gt  = (st_dist > best_q);

  knn_store #(
    .MAX_K      (MAX_K),
    .NUM_POINTS (NUM_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .pt_i    (st_pt),
    .slot_i  (st_slot),
    .id_i    (nb_q),
    .dist_i  (dist_q),
    .marks_i (st_wr_marks),
    .cnt_i   (st_wr_cnt),
    .id_o    (st_id),
    .dist_o  (st_dist),
    .marks_o (st_marks),
    .cnt_o   (st_cnt)
  );

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_count_q <= knn_pkg::KCountReset;
    end else if (cfg_we_i) begin
      k_count_q <= cfg_wdata_i;
    end
  end

  // Sequencer with result staging and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      op_q        <= knn_pkg::OpUpdate;
      pt_q        <= '0;
      pt_ok_q     <= 1'b0;
      slot_q      <= '0;
      slot_ok_q   <= 1'b0;
      nb_q        <= '0;
      dist_q      <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      dup_q       <= 1'b0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_idx_q  <= '0;
      clr_q       <= '0;
      res_upd_q   <= 1'b0;
      res_nb_q    <= '0;
      res_dist_q  <= '0;
      res_new_q   <= 1'b0;
      res_empty_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_upd_q   <= 1'b0;
      out_nb_q    <= '0;
      out_dist_q  <= '0;
      out_new_q   <= 1'b0;
      out_empty_q <= 1'b0;
    end else begin
      // Load a finished result, drop it once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + PW'(1);
          if (clr_q == PW'(NUM_POINTS - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid_i) begin
            op_q      <= knn_pkg::knn_op_e'(opcode_i);
            pt_q      <= pt_ext[PW-1:0];
            pt_ok_q   <= (pt_ext < NUM_POINTS);
            slot_q    <= slot_ext[SW-1:0];
            slot_ok_q <= (slot_ext < MAX_K);
            nb_q      <= neighbor_i;
            dist_q    <= distance_i;
            state_q   <= S_FETCH;
          end
        end

        S_FETCH: begin
          state_q <= S_DECIDE;
        end

        S_DECIDE: begin
          res_upd_q   <= do_fill;
          res_nb_q    <= '0;
          res_dist_q  <= '0;
          res_new_q   <= 1'b0;
          res_empty_q <= 1'b0;
          if (pt_ok_q && (op_q == knn_pkg::OpUpdate) && list_full) begin
            // Full list: scan for a duplicate and the first largest distance
            idx_q      <= '0;
            pend_q     <= 1'b0;
            dup_q      <= 1'b0;
            found_q    <= 1'b0;
            best_q     <= '0;
            best_idx_q <= '0;
            state_q    <= S_SCAN;
          end else begin
            if (op_valid && (op_q inside {knn_pkg::OpRead, knn_pkg::OpReadClear})) begin
              res_nb_q    <= st_id;
              res_dist_q  <= slot_empty ? '0 : st_dist;
              res_new_q   <= st_marks[slot_q];
              res_empty_q <= slot_empty;
            end
            state_q <= S_OUT;
          end
        end

        S_SCAN: begin
          if (pend_q) begin
            if (scan_dup) begin
              dup_q <= 1'b1;
            end
            if (scan_gt) begin
              best_q     <= st_dist;
              best_idx_q <= pend_idx_q;
              found_q    <= 1'b1;
            end
          end
          pend_q     <= 1'b1;
          pend_idx_q <= idx_q;
          if (idx_q == last_idx) begin
            state_q <= S_TAIL;
          end else begin
            idx_q <= idx_q + SW'(1);
          end
        end

        S_TAIL: begin
          // Fold in the last slot read
          if (scan_dup) begin
            dup_q <= 1'b1;
          end
          if (scan_gt) begin
            best_q     <= st_dist;
            best_idx_q <= pend_idx_q;
            found_q    <= 1'b1;
          end
          pend_q  <= 1'b0;
          state_q <= S_EVAL;
        end

        S_EVAL: begin
          res_upd_q <= do_rep;
          state_q   <= S_OUT;
        end

        S_OUT: begin
          // Advance into the output register when it is free
          if (out_load) begin
            out_upd_q   <= res_upd_q;
            out_nb_q    <= res_nb_q;
            out_dist_q  <= res_dist_q;
            out_new_q   <= res_new_q;
            out_empty_q <= res_empty_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_FETCH)
    else $error("accepted beat did not start a fetch");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> we == '0)
    else $error("store written while idle");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> idx_q <= last_idx)
    else $error("scan index beyond the last slot in use");

  a_update_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && updated_o |->
      !entry_empty_o && !entry_is_new_o && entry_distance_o == '0
      && entry_neighbor_o == '0)
    else $error("update result carries entry fields");

  a_empty_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_empty_o |-> entry_distance_o == '0)
    else $error("empty slot reported with a distance");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none

module tb;

  localparam int unsigned OpW    = knn_pkg::OpW;
  localparam int unsigned PointW = knn_pkg::PointW;
  localparam int unsigned SlotW  = knn_pkg::SlotW;
  localparam int unsigned NbW    = knn_pkg::NbW;
  localparam int unsigned DistW  = knn_pkg::DistW;
  localparam int unsigned KCntW  = knn_pkg::KCntW;

  localparam int unsigned MAX_SLOTS     = knn_pkg::MaxKDefault;
  localparam int unsigned NUM_PTS       = knn_pkg::NumPointsDefault;
  localparam int          SETTLE_CYCLES = knn_pkg::MaxKDefault + 8;
  localparam int          STALL_LIMIT   = 8000;
  localparam int          PHASES        = 8;
  localparam int          ITEMS_PER_PH  = 175;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct packed {
    logic             updated;
    logic [NbW-1:0]   nb;
    logic [DistW-1:0] distance;
    logic             is_new;
    logic             empty;
  } list_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [KCntW-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [OpW-1:0]      opcode_i;
  logic [PointW-1:0]   point_i;
  logic [SlotW-1:0]    slot_i;
  logic [NbW-1:0]      neighbor_i;
  logic [DistW-1:0]    distance_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                updated_o;
  logic [NbW-1:0]      entry_neighbor_o;
  logic [DistW-1:0]    entry_distance_o;
  logic                entry_is_new_o;
  logic                entry_empty_o;

  // Shadow copy of the neighbor lists and the slot count register
  logic [NbW-1:0]   list_ids   [NUM_PTS][MAX_SLOTS];
  logic [DistW-1:0] list_dists [NUM_PTS][MAX_SLOTS];
  bit               list_new   [NUM_PTS][MAX_SLOTS];
  bit               id_known   [NUM_PTS][MAX_SLOTS];
  int               fill_cnt   [NUM_PTS];
  logic [KCntW-1:0] k_reg;

  list_result_t      pending_results[$];
  logic [PointW-1:0] hot_points [4];
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                mismatch_count = 0;
  int                quiet_cycles   = 0;

  knn_neighbor_list_update #(
    .MAX_K      (knn_pkg::MaxKDefault),
    .NUM_POINTS (knn_pkg::NumPointsDefault)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .point_i          (point_i),
    .slot_i           (slot_i),
    .neighbor_i       (neighbor_i),
    .distance_i       (distance_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .updated_o        (updated_o),
    .entry_neighbor_o (entry_neighbor_o),
    .entry_distance_o (entry_distance_o),
    .entry_is_new_o   (entry_is_new_o),
    .entry_empty_o    (entry_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one request to the shadow lists and return the result it produces
  function automatic list_result_t apply_list_op(input knn_pkg::knn_op_e op,
      input logic [PointW-1:0] p, input logic [SlotW-1:0] s,
      input logic [NbW-1:0] nb, input logic [DistW-1:0] d);
    list_result_t     res;
    int               k;
    int               cnt;
    int               worst;
    logic             dup;
    logic [DistW-1:0] worst_dist;
    res = '0;
    k = (k_reg == 0) ? 1 : (k_reg > MAX_SLOTS) ? MAX_SLOTS : int'(k_reg);
    cnt = fill_cnt[p];
    case (op)
      knn_pkg::OpUpdate: begin
        if (cnt < k) begin
          // fill the next empty slot, no duplicate check
          list_ids[p][cnt]   = nb;
          list_dists[p][cnt] = d;
          list_new[p][cnt]   = 1'b1;
          id_known[p][cnt]   = 1'b1;
          fill_cnt[p]        = cnt + 1;
          res.updated        = 1'b1;
        end else begin
          dup = 1'b0;
          for (int j = 0; j < k; j++)
            if (list_ids[p][j] == nb) dup = 1'b1;
          // first slot holding the largest distance; none if all are zero
          worst = -1;
          worst_dist = '0;
          for (int j = 0; j < k; j++) begin
            if (list_dists[p][j] > worst_dist) begin
              worst_dist = list_dists[p][j];
              worst = j;
            end
          end
          if (!dup && worst >= 0 && d < worst_dist) begin
            list_ids[p][worst]   = nb;
            list_dists[p][worst] = d;
            list_new[p][worst]   = 1'b1;
            res.updated          = 1'b1;
          end
        end
      end
      knn_pkg::OpSeed: begin
        list_ids[p][s] = nb;
        id_known[p][s] = 1'b1;
      end
      default: begin
        res.empty    = (s >= cnt);
        res.nb       = list_ids[p][s];
        res.distance = res.empty ? '0 : list_dists[p][s];
        res.is_new   = list_new[p][s];
        if (op == knn_pkg::OpReadClear) list_new[p][s] = 1'b0;
      end
    endcase
    return res;
  endfunction

  // Randomize the receiver's ready every cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result beat against the oldest expectation; watch for a hang
  always @(posedge clk_i) begin : check_results
    list_result_t got;
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{updated_o, entry_neighbor_o, entry_distance_o, entry_is_new_o,
              entry_empty_o};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: upd=%0d nb=%0d dist=%h new=%0d empty=%0d",
                   got.updated, got.nb, got.distance, got.is_new, got.empty);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch at %0t:", $realtime);
            $display("  expected upd=%0d nb=%0d dist=%h new=%0d empty=%0d",
                     want.updated, want.nb, want.distance, want.is_new, want.empty);
            $display("  actual   upd=%0d nb=%0d dist=%h new=%0d empty=%0d",
                     got.updated, got.nb, got.distance, got.is_new, got.empty);
          end
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      IdleNone:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IdleSender:   begin send_idle_pct = 77; recv_stall_pct = 0;  end
      IdleReceiver: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      default:      begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
  endtask

  // Send one request beat and queue its expected result at acceptance
  task automatic send_req(input knn_pkg::knn_op_e op, input logic [PointW-1:0] p,
      input logic [SlotW-1:0] s, input logic [NbW-1:0] nb,
      input logic [DistW-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    point_i    <= p;
    slot_i     <= s;
    neighbor_i <= nb;
    distance_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.insert(pending_results.size(), apply_list_op(op, p, s, nb, d));
  endtask

  // Hold off requests until every result is back, then let the block settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_slot_count(input logic [KCntW-1:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    k_reg = v;
  endtask

  // Seed a slot past the fill count, read it, clear its mark, read again
  task automatic test_seed_and_read();
    send_req(knn_pkg::OpSeed,      10'd1023, 4'd15, 10'd1023, '1);
    send_req(knn_pkg::OpRead,      10'd1023, 4'd15, 10'd0,    '0);
    send_req(knn_pkg::OpReadClear, 10'd1023, 4'd15, 10'd1023, '1);
    send_req(knn_pkg::OpRead,      10'd1023, 4'd15, 10'd0,    '0);
    send_req(knn_pkg::OpSeed,      10'd0,    4'd0,  10'd0,    '0);
  endtask

  // Fill, duplicate refusal, strict compare, all-zero lists, replacement
  task automatic test_fill_and_replace();
    write_slot_count(5'd2);
    send_req(knn_pkg::OpUpdate,    10'd0, 4'd0, 10'd5, 32'd0);
    send_req(knn_pkg::OpUpdate,    10'd0, 4'd0, 10'd7, 32'd0);
    send_req(knn_pkg::OpUpdate,    10'd0, 4'd0, 10'd9, 32'd0);
    send_req(knn_pkg::OpUpdate,    10'd1, 4'd0, 10'd1, 32'hFFFF_FFFF);
    send_req(knn_pkg::OpUpdate,    10'd1, 4'd0, 10'd2, 32'd10);
    send_req(knn_pkg::OpUpdate,    10'd1, 4'd0, 10'd1, 32'd0);
    send_req(knn_pkg::OpUpdate,    10'd1, 4'd0, 10'd3, 32'hFFFF_FFFF);
    send_req(knn_pkg::OpUpdate,    10'd1, 4'd0, 10'd4, 32'hFFFF_FFFE);
    send_req(knn_pkg::OpRead,      10'd1, 4'd0, 10'd0, 32'd0);
    send_req(knn_pkg::OpReadClear, 10'd1, 4'd0, 10'd0, 32'd0);
    send_req(knn_pkg::OpRead,      10'd1, 4'd0, 10'd0, 32'd0);
    send_req(knn_pkg::OpRead,      10'd0, 4'd1, 10'd0, 32'd0);
  endtask

  // Lower the slot count below the fill count, saturate it, raise it again
  task automatic test_slot_count_change();
    write_slot_count(5'd1);
    send_req(knn_pkg::OpUpdate, 10'd1, 4'd0, 10'd2, 32'd1);
    write_slot_count(5'd0);
    send_req(knn_pkg::OpUpdate, 10'd1, 4'd0, 10'd2, 32'd0);
    write_slot_count(5'd31);
    send_req(knn_pkg::OpUpdate, 10'd1, 4'd0, 10'd6, 32'd7);
    send_req(knn_pkg::OpRead,   10'd1, 4'd2, 10'd0, 32'd0);
  endtask

  // One random request, mostly updates on a few hot points so lists fill up
  task automatic send_random_item();
    logic [PointW-1:0] p;
    logic [SlotW-1:0]  s;
    logic [NbW-1:0]    nb;
    logic [DistW-1:0]  d;
    knn_pkg::knn_op_e  op;
    int                r;
    int                cnt;
    p   = ($urandom_range(19) == 0) ? PointW'($urandom) : hot_points[$urandom_range(3)];
    s   = SlotW'($urandom);
    nb  = NbW'($urandom);
    d   = $urandom;
    cnt = fill_cnt[p];
    r   = $urandom_range(99);
    if (r < 55) begin
      op = knn_pkg::OpUpdate;
      // offer a listed id now and then, and distances near the stored ones
      if (cnt > 0 && $urandom_range(3) == 0) nb = list_ids[p][$urandom_range(cnt - 1)];
      case ($urandom_range(7))
        0: d = '0;
        1: d = '1;
        2, 3: if (cnt > 0)
          d = list_dists[p][$urandom_range(cnt - 1)] + DistW'($urandom_range(2)) - 1;
        4: d = {16'($urandom_range(15)), 16'($urandom)};
        default: ;
      endcase
    end else if (r < 90) begin
      op = (r < 73) ? knn_pkg::OpRead : knn_pkg::OpReadClear;
      // never read an id that was not written
      if (!id_known[p][s]) begin
        if (cnt > 0) s = SlotW'($urandom_range(cnt - 1));
        else op = knn_pkg::OpSeed;
      end
    end else begin
      op = knn_pkg::OpSeed;
    end
    send_req(op, p, s, nb, d);
  endtask

  task automatic test_random_traffic();
    logic [KCntW-1:0] kv;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: kv = 5'd16;
        1: kv = 5'd3;
        2: kv = 5'd1;
        3: kv = 5'd31;
        4: kv = 5'd0;
        5: kv = 5'd6;
        6: kv = 5'd2;
        default: kv = 5'd16;
      endcase
      write_slot_count(kv);
      set_idle_mode(idle_mode_e'(ph % 4));
      if (ph % 2 == 0)
        foreach (hot_points[i]) hot_points[i] = PointW'($urandom);
      for (int i = 0; i < ITEMS_PER_PH; i++) begin
        // pause mid-phase until the block has answered everything
        if (i == ITEMS_PER_PH / 2) drain_results();
        send_random_item();
      end
    end
  endtask

  initial begin
    foreach (list_ids[p, s]) begin
      list_ids[p][s]   = '0;
      list_dists[p][s] = '0;
      list_new[p][s]   = 1'b1;
      id_known[p][s]   = 1'b0;
    end
    foreach (fill_cnt[p]) fill_cnt[p] = 0;
    k_reg       = knn_pkg::KCountReset;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    opcode_i    = '0;
    point_i     = '0;
    slot_i      = '0;
    neighbor_i  = '0;
    distance_i  = '0;
    out_ready_i = 1'b0;
    set_idle_mode(IdleNone);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_seed_and_read();
    test_fill_and_replace();
    test_slot_count_change();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
